FILE: src/brt_pkg.sv
// Shared types, constants and helpers for the binary radix trie prefix table.
package brt_pkg;

  localparam int NODE_COUNT = 4096;
  localparam int NODE_BITS  = $clog2(NODE_COUNT);
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int LVL_BITS   = $clog2(KEY_BITS) + 1;
  localparam int KIX_BITS   = $clog2(KEY_BITS);

  // Request codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_FIND   = 2'd2;

  // Status codes
  localparam logic [1:0] ST_MATCH   = 2'd0;
  localparam logic [1:0] ST_PARTIAL = 2'd1;
  localparam logic [1:0] ST_DUP     = 2'd2;
  localparam logic [1:0] ST_ERR     = 2'd3;

  typedef logic [NODE_BITS-1:0] node_idx_t;

  // One node memory entry
  typedef struct packed {
    node_idx_t              left;
    node_idx_t              right;
    node_idx_t              parent;
    logic                   valid;
    logic [VALUE_BITS-1:0]  value;
  } node_t;

  // Reverse the byte order of a key
  function automatic logic [KEY_BITS-1:0] swap_bytes(input logic [KEY_BITS-1:0] x);
    logic [KEY_BITS-1:0] r;
    r = '0;
    for (int i = 0; i < KEY_BITS / 8; i++) begin
      r[8*i +: 8] = x[KEY_BITS - 8 - 8*i +: 8];
    end
    return r;
  endfunction

endpackage

FILE: src/brt_req_if.sv
// Request channel: valid/ready handshake with the lookup request word.
interface brt_req_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        req_type;
  logic [brt_pkg::KEY_BITS-1:0]      key;
  logic [brt_pkg::KEY_BITS-1:0]      mask;
  logic [brt_pkg::VALUE_BITS-1:0]    entry_value;
  logic                              shortest_prefix;

  modport source (output valid, req_type, key, mask, entry_value, shortest_prefix,
                  input ready);
  modport sink (input valid, req_type, key, mask, entry_value, shortest_prefix,
                output ready);
endinterface

FILE: src/brt_rsp_if.sv
// Response channel: valid/ready handshake with the result word.
interface brt_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        status;
  logic [brt_pkg::VALUE_BITS-1:0]    found_value;
  logic                              value_present;

  modport source (output valid, status, found_value, value_present, input ready);
  modport sink (input valid, status, found_value, value_present, output ready);
endinterface

FILE: src/binary_radix_trie_prefix_table_unit.sv
// Top level of the binary radix trie prefix table.
//
// Requests arrive on req (insert, delete, find of a key/mask prefix); one result
// word per request leaves on rsp. cfg_we/cfg_wdata set the byte swap register.
// One request is handled at a time. A walk reads the node memory, then
// evaluates, at each trie level. Insert then builds each missing node
// (allocate, optional free list pop, link) and sets the value in a final
// step. Delete prunes back up the path, with a fetch and an evaluate for
// each freed node. The node memory's registered read sets this pattern.
// The root entry lives in flip-flops, so reset alone empties the table: no
// clearing pass is needed and req is ready as soon as reset drops.
// The result sits in an output register; the next request is taken while it
// waits, but a second finished result holds the unit until rsp is taken.
module binary_radix_trie_prefix_table_unit (
  input  logic       clk,
  input  logic       rst,
  brt_req_if.sink    req,
  brt_rsp_if.source  rsp,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_EVAL, S_PR_FETCH, S_PR_EVAL,
    S_CR_ALLOC, S_CR_POP, S_CR_LINK, S_CR_FINAL, S_DONE
  } state_t;

  state_t                           state;
  logic                             byte_swap;
  logic [1:0]                       req_type;
  logic [brt_pkg::KEY_BITS-1:0]     key;
  logic [brt_pkg::KEY_BITS-1:0]     msk;
  logic [brt_pkg::VALUE_BITS-1:0]   val;
  logic                             prefix;
  brt_pkg::node_idx_t               node;
  brt_pkg::node_idx_t               child;
  brt_pkg::node_idx_t               nn;
  logic [brt_pkg::LVL_BITS-1:0]     lvl;
  brt_pkg::node_t                   w;
  brt_pkg::node_idx_t               free_head;
  logic [brt_pkg::NODE_BITS:0]      next_fresh;
  logic [1:0]                       res_status;
  logic [brt_pkg::VALUE_BITS-1:0]   res_value;
  logic                             res_present;

  // root entry in flops
  brt_pkg::node_idx_t               root_left;
  brt_pkg::node_idx_t               root_right;
  logic                             root_valid;
  logic [brt_pkg::VALUE_BITS-1:0]   root_value;

  // memory port
  logic                             wr_en;
  brt_pkg::node_idx_t               wr_node;
  brt_pkg::node_t                   wr_data;
  logic                             rd_en;
  brt_pkg::node_idx_t               rd_addr;
  brt_pkg::node_t                   rdata;

  brt_pkg::node_t                   cur;
  brt_pkg::node_t                   freed;
  brt_pkg::node_idx_t               nx;
  logic                             more;
  logic                             more_next;
  logic [brt_pkg::LVL_BITS-1:0]     lvl_p1;
  logic                             leaf;
  logic                             is_root;
  brt_pkg::node_idx_t               pl;
  brt_pkg::node_idx_t               pr;
  logic                             pr_stop;
  logic                             in_acc;

  brt_node_mem u_mem (
    .clk   (clk),
    .we    (wr_en && (wr_node != '0)),
    .waddr (wr_node),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign in_acc    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);

  // current entry, next child and walk conditions
  always_comb begin
    is_root   = (node == '0);
    cur       = is_root ? '{left: root_left, right: root_right, parent: '0,
                            valid: root_valid, value: root_value} : rdata;
    more      = (lvl < brt_pkg::LVL_BITS'(brt_pkg::KEY_BITS)) &&
                msk[~lvl[brt_pkg::KIX_BITS-1:0]];
    lvl_p1    = lvl + 1'b1;
    more_next = (lvl_p1 < brt_pkg::LVL_BITS'(brt_pkg::KEY_BITS)) &&
                msk[~lvl_p1[brt_pkg::KIX_BITS-1:0]];
    nx        = key[~lvl[brt_pkg::KIX_BITS-1:0]] ? cur.right : cur.left;
    leaf      = (cur.left == '0) && (cur.right == '0);
    freed     = '{left: '0, right: free_head, parent: cur.parent, valid: 1'b0,
                  value: cur.value};
    // unlink the child just freed
    pl        = cur.left;
    pr        = cur.right;
    if (cur.right == child) begin
      pr = '0;
    end else begin
      pl = '0;
    end
    pr_stop   = (pl != '0) || (pr != '0) || cur.valid || is_root;
  end

  // memory access per state
  always_comb begin
    wr_en   = 1'b0;
    wr_node = node;
    wr_data = cur;
    rd_en   = 1'b0;
    rd_addr = node;
    case (state)
      S_FETCH, S_PR_FETCH: begin
        rd_en = 1'b1;
      end
      S_EVAL: begin
        if (!more && req_type == brt_pkg::REQ_INSERT && !cur.valid) begin
          wr_en         = 1'b1;
          wr_data.valid = 1'b1;
          wr_data.value = val;
        end else if (!more && req_type == brt_pkg::REQ_DELETE && cur.valid) begin
          wr_en = 1'b1;
          if (is_root || !leaf) begin
            wr_data.valid = 1'b0;
          end else begin
            wr_data = freed;
          end
        end
      end
      S_PR_EVAL: begin
        wr_en = 1'b1;
        if (pr_stop) begin
          wr_data.left  = pl;
          wr_data.right = pr;
        end else begin
          wr_data = freed;
        end
      end
      S_CR_ALLOC: begin
        wr_en   = 1'b1;
        wr_data = w;
        if (free_head != '0) begin
          rd_en   = 1'b1;
          rd_addr = free_head;
        end
      end
      S_CR_LINK: begin
        wr_en   = 1'b1;
        wr_data = w;
        if (key[~lvl[brt_pkg::KIX_BITS-1:0]]) begin
          wr_data.right = nn;
        end else begin
          wr_data.left = nn;
        end
      end
      S_CR_FINAL: begin
        wr_en         = 1'b1;
        wr_data       = w;
        wr_data.valid = 1'b1;
        wr_data.value = val;
      end
      default: begin
      end
    endcase
  end

  // root entry and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      root_left  <= '0;
      root_right <= '0;
      root_valid <= 1'b0;
      byte_swap  <= 1'b0;
    end else begin
      if (cfg_we) begin
        byte_swap <= cfg_wdata;
      end
      if (wr_en && wr_node == '0) begin
        root_left  <= wr_data.left;
        root_right <= wr_data.right;
        root_valid <= wr_data.valid;
      end
    end
    if (wr_en && wr_node == '0) begin
      root_value <= wr_data.value;
    end
  end

  // request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      free_head  <= '0;
      next_fresh <= (brt_pkg::NODE_BITS+1)'(1);
      lvl        <= '0;
      node       <= '0;
      rsp.valid  <= 1'b0;
    end else begin
      // S_DONE sets valid itself when the slot frees
      if (rsp.valid && rsp.ready && state != S_DONE) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            req_type    <= req.req_type;
            key         <= byte_swap ? brt_pkg::swap_bytes(req.key) : req.key;
            msk         <= byte_swap ? brt_pkg::swap_bytes(req.mask) : req.mask;
            val         <= req.entry_value;
            prefix      <= req.shortest_prefix;
            node        <= '0;
            lvl         <= '0;
            res_status  <= brt_pkg::ST_ERR;
            res_value   <= '0;
            res_present <= 1'b0;
            if (req.req_type inside {brt_pkg::REQ_INSERT, brt_pkg::REQ_DELETE,
                                     brt_pkg::REQ_FIND}) begin
              state <= S_FETCH;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_FETCH: begin
          state <= S_EVAL;
        end
        S_PR_FETCH: begin
          state <= S_PR_EVAL;
        end
        S_EVAL: begin
          if (more) begin
            if (req_type == brt_pkg::REQ_FIND && prefix && cur.valid) begin
              res_status  <= brt_pkg::ST_PARTIAL;
              res_value   <= cur.value;
              res_present <= 1'b1;
              state       <= S_DONE;
            end else if (nx != '0) begin
              node  <= nx;
              lvl   <= lvl_p1;
              state <= S_FETCH;
            end else if (req_type == brt_pkg::REQ_INSERT) begin
              w     <= cur;
              state <= S_CR_ALLOC;
            end else begin
              state <= S_DONE;
            end
          end else if (req_type == brt_pkg::REQ_INSERT) begin
            res_status <= cur.valid ? brt_pkg::ST_DUP : brt_pkg::ST_MATCH;
            state      <= S_DONE;
          end else if (cur.valid) begin
            res_status  <= brt_pkg::ST_MATCH;
            res_value   <= cur.value;
            res_present <= 1'b1;
            if (req_type == brt_pkg::REQ_DELETE && !is_root && leaf) begin
              free_head <= node;
              child     <= node;
              node      <= cur.parent;
              state     <= S_PR_FETCH;
            end else begin
              state <= S_DONE;
            end
          end else begin
            state <= S_DONE;
          end
        end
        S_PR_EVAL: begin
          if (pr_stop) begin
            state <= S_DONE;
          end else begin
            free_head <= node;
            child     <= node;
            node      <= cur.parent;
            state     <= S_PR_FETCH;
          end
        end
        S_CR_ALLOC: begin
          if (free_head != '0) begin
            nn    <= free_head;
            state <= S_CR_POP;
          end else if (!next_fresh[brt_pkg::NODE_BITS]) begin
            nn         <= next_fresh[brt_pkg::NODE_BITS-1:0];
            next_fresh <= next_fresh + 1'b1;
            state      <= S_CR_LINK;
          end else begin
            state <= S_DONE;
          end
        end
        S_CR_POP: begin
          free_head <= rdata.right;
          state     <= S_CR_LINK;
        end
        S_CR_LINK: begin
          w     <= '{left: '0, right: '0, parent: node, valid: 1'b0, value: '0};
          node  <= nn;
          lvl   <= lvl_p1;
          state <= more_next ? S_CR_ALLOC : S_CR_FINAL;
        end
        S_CR_FINAL: begin
          res_status <= brt_pkg::ST_MATCH;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.status        <= res_status;
      rsp.found_value   <= res_value;
      rsp.value_present <= res_present;
    end
  end

  // checks
  a_fresh_bound: assert property (@(posedge clk) disable iff (rst)
    next_fresh <= (brt_pkg::NODE_BITS+1)'(brt_pkg::NODE_COUNT))
    else $error("fresh node counter past pool size");

  a_free_alloc: assert property (@(posedge clk) disable iff (rst)
    (free_head != '0) |-> ({1'b0, free_head} < next_fresh))
    else $error("free list head was never allocated");

  a_port_clash: assert property (@(posedge clk) disable iff (rst)
    (rd_en && wr_en && wr_node != '0) |-> (rd_addr != wr_node))
    else $error("read and write of the same node in one cycle");

  a_level: assert property (@(posedge clk) disable iff (rst)
    lvl <= brt_pkg::LVL_BITS'(brt_pkg::KEY_BITS))
    else $error("walk level past key width");

endmodule

FILE: src/brt_node_mem.sv
// Node memory: one write port, one registered read port.
module brt_node_mem (
  input  logic                clk,
  input  logic                we,
  input  brt_pkg::node_idx_t  waddr,
  input  brt_pkg::node_t      wdata,
  input  logic                re,
  input  brt_pkg::node_idx_t  raddr,
  output brt_pkg::node_t      rdata
);

  brt_pkg::node_t mem [brt_pkg::NODE_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sim/tb.sv
// Testbench for the binary radix trie prefix table: random and directed requests, scoreboard.
module tb;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int LIMIT = 1500000;
  localparam int SETTLE = 200;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] key;
    logic [31:0] mask;
    logic [31:0] value;
    logic        sp;
  } lookup_word_t;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] value;
    logic        present;
  } result_word_t;

  function automatic logic [31:0] rev_bytes(logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  // Trie mirror plus queue of expected result words
  class trie_scoreboard;
    bit [11:0] lf[brt_pkg::NODE_COUNT];
    bit [11:0] rt[brt_pkg::NODE_COUNT];
    bit [11:0] par[brt_pkg::NODE_COUNT];
    bit [31:0] val[brt_pkg::NODE_COUNT];
    bit        vld[brt_pkg::NODE_COUNT];
    bit [11:0] free_head;
    int        next_fresh = 1;
    bit        swap;
    int        errors;
    result_word_t pending_q[$];

    function int pending();
      return pending_q.size();
    endfunction

    function bit is_leaf(int n);
      return lf[n] == 0 && rt[n] == 0;
    endfunction

    function int alloc_node();
      int n;
      if (free_head != 0) begin
        n = free_head;
        free_head = rt[n];
      end else if (next_fresh < brt_pkg::NODE_COUNT) begin
        n = next_fresh;
        next_fresh++;
      end else begin
        return -1;
      end
      lf[n] = 0;
      rt[n] = 0;
      vld[n] = 0;
      val[n] = 0;
      return n;
    endfunction

    function logic [1:0] insert_prefix(logic [31:0] k, logic [31:0] m, logic [31:0] v);
      int node, i, n;
      bit walked;
      bit [11:0] nx;
      node = 0;
      i = 31;
      walked = 1;
      while (i >= 0 && m[i]) begin
        nx = k[i] ? rt[node] : lf[node];
        if (nx == 0) begin
          walked = 0;
          break;
        end
        node = nx;
        i--;
      end
      if (walked && vld[node]) return brt_pkg::ST_DUP;
      while (i >= 0 && m[i]) begin
        n = alloc_node();
        if (n < 0) return brt_pkg::ST_ERR;
        par[n] = 12'(node);
        if (k[i]) rt[node] = 12'(n);
        else lf[node] = 12'(n);
        i--;
        node = n;
      end
      val[node] = v;
      vld[node] = 1;
      return brt_pkg::ST_MATCH;
    endfunction

    function logic [1:0] walk_to(logic [31:0] k, logic [31:0] m, bit sp, output int node);
      int i;
      bit alive;
      logic [1:0] rc;
      bit [11:0] nx;
      node = 0;
      i = 31;
      alive = 1;
      rc = brt_pkg::ST_ERR;
      while (alive && i >= 0 && m[i]) begin
        if (sp && vld[node]) begin
          rc = brt_pkg::ST_PARTIAL;
          break;
        end
        nx = k[i] ? rt[node] : lf[node];
        if (nx == 0) alive = 0;
        else node = nx;
        i--;
      end
      if (alive && rc == brt_pkg::ST_ERR && vld[node]) rc = brt_pkg::ST_MATCH;
      return alive ? rc : brt_pkg::ST_ERR;
    endfunction

    // Clear the valid flag, then free empty leaves back up the path (root never freed)
    function void prune_path(int node);
      int p;
      if (node == 0 || !is_leaf(node)) begin
        vld[node] = 0;
        return;
      end
      for (int s = 0; s <= 32; s++) begin
        p = par[node];
        if (rt[p] == node) rt[p] = 0;
        else lf[p] = 0;
        lf[node] = 0;
        rt[node] = free_head;
        vld[node] = 0;
        free_head = 12'(node);
        node = p;
        if (!is_leaf(node) || vld[node] || node == 0) break;
      end
    endfunction

    function void note_request(lookup_word_t w);
      result_word_t r;
      logic [31:0] k, m;
      logic [1:0] rc;
      int node;
      k = swap ? rev_bytes(w.key) : w.key;
      m = swap ? rev_bytes(w.mask) : w.mask;
      r = '{brt_pkg::ST_ERR, 32'd0, 1'b0};
      case (w.op)
        brt_pkg::REQ_INSERT: r.status = insert_prefix(k, m, w.value);
        brt_pkg::REQ_DELETE: begin
          if (walk_to(k, m, 0, node) == brt_pkg::ST_MATCH) begin
            r = '{brt_pkg::ST_MATCH, val[node], 1'b1};
            prune_path(node);
          end
        end
        brt_pkg::REQ_FIND: begin
          rc = walk_to(k, m, w.sp, node);
          if (rc != brt_pkg::ST_ERR) r = '{rc, val[node], 1'b1};
        end
        default: ;
      endcase
      pending_q.push_back(r);
    endfunction

    function void check_result(result_word_t got);
      result_word_t exp;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result status=%0d value=%h present=%0d",
                 $time, got.status, got.value, got.present);
        errors++;
        return;
      end
      exp = pending_q.pop_front();
      if (got.status !== exp.status) begin
        $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
        errors++;
      end
      if (got.value !== exp.value) begin
        $display("%0t: found_value exp %h got %h", $time, exp.value, got.value);
        errors++;
      end
      if (got.present !== exp.present) begin
        $display("%0t: value_present exp %0d got %0d", $time, exp.present, got.present);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic cfg_wdata = 0;
  brt_req_if req_ch();
  brt_rsp_if rsp_ch();

  binary_radix_trie_prefix_table_unit DUT (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  trie_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_start = 0;
  int hold_left = 0;
  int cycles = 0;
  logic [31:0] key_pool[16];
  logic [31:0] full_keys[$];

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Receiver: random stalls and a long hold-off on request
  initial rsp_ch.ready = 0;
  always @(negedge clk) begin
    if (hold_start) begin
      hold_left = 600;
      hold_start = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready = 0;
    end else begin
      rsp_ch.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      sb.check_result('{rsp_ch.status, rsp_ch.found_value, rsp_ch.value_present});
  end

  initial begin
    req_ch.valid = 0;
    req_ch.req_type = brt_pkg::REQ_INSERT;
    req_ch.key = 0;
    req_ch.mask = 0;
    req_ch.entry_value = 0;
    req_ch.shortest_prefix = 0;
  end

  task automatic send_word(lookup_word_t w);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      req_ch.valid = 0;
      @(negedge clk);
    end
    req_ch.valid = 1;
    req_ch.req_type = w.op;
    req_ch.key = w.key;
    req_ch.mask = w.mask;
    req_ch.entry_value = w.value;
    req_ch.shortest_prefix = w.sp;
    do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
    sb.note_request(w);
  endtask

  task automatic send(logic [1:0] op, logic [31:0] k, logic [31:0] m,
                      logic [31:0] v = 0, logic sp = 0);
    send_word('{op, k, m, v, sp});
  endtask

  // Drop valid and wait for every outstanding result, then let the unit settle
  task automatic drain();
    @(negedge clk);
    req_ch.valid = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_swap(bit v);
    @(negedge clk);
    cfg_we = 1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 0;
    sb.swap = v;
  endtask

  // Prefix on a pooled key (else a fully random word): depth mostly shallow, bits below the prefix random
  function automatic lookup_word_t random_word();
    lookup_word_t w;
    int depth, pick;
    logic [31:0] m;
    pick = $urandom_range(99);
    w.value = $urandom;
    w.sp = $urandom_range(1);
    if (pick < 10) begin
      w.op = $urandom_range(3);
      w.key = $urandom;
      w.mask = $urandom;
      return w;
    end
    w.op = pick < 50 ? brt_pkg::REQ_INSERT :
           (pick < 72 ? brt_pkg::REQ_DELETE : brt_pkg::REQ_FIND);
    depth = $urandom_range(99) < 80 ? $urandom_range(0, 10) : $urandom_range(11, 32);
    m = depth == 0 ? 32'd0 : ~32'd0 << (32 - depth);
    w.key = (key_pool[$urandom_range(15)] & m) | ($urandom & ~m);
    if (depth < 32) m = m | ($urandom & ~(~32'd0 << (31 - depth)));
    w.mask = sb.swap ? rev_bytes(m) : m;
    w.key = sb.swap ? rev_bytes(w.key) : w.key;
    return w;
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) send_word(random_word());
  endtask

  initial begin
    logic [31:0] k;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: root, extremes, unused code, partial match, pruning
    send(brt_pkg::REQ_INSERT, 32'h0, 32'h0, 32'h1234_5678);
    send(brt_pkg::REQ_INSERT, 32'hffff_ffff, 32'h0f0f_0f0f, 32'h1);
    send(brt_pkg::REQ_FIND, 32'h0, 32'h0);
    send(brt_pkg::REQ_INSERT, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send(brt_pkg::REQ_INSERT, 32'h0, 32'hffff_ffff, 32'h0);
    send(brt_pkg::REQ_FIND, 32'hffff_ffff, 32'hffff_ffff, 0, 1);
    send(brt_pkg::REQ_FIND, 32'hffff_ffff, 32'hffff_ffff, 0, 0);
    send(brt_pkg::REQ_DELETE, 32'h0, 32'h0);
    send(brt_pkg::REQ_DELETE, 32'h0, 32'h0);
    send(brt_pkg::REQ_FIND, 32'h0, 32'h0);
    send(brt_pkg::REQ_INSERT, 32'hab00_0000, 32'hff00_0000, 32'hab);
    send(brt_pkg::REQ_FIND, 32'habcd_ef12, 32'hffff_ffff, 0, 1);
    send(brt_pkg::REQ_FIND, 32'habcd_ef12, 32'hffff_ffff, 0, 0);
    send(brt_pkg::REQ_FIND, 32'hab12_3456, 32'hff00_ffff, 0, 0);
    send(REQ_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1);
    send(brt_pkg::REQ_DELETE, 32'hffff_ffff, 32'hffff_ffff);
    send(brt_pkg::REQ_FIND, 32'hffff_ffff, 32'hffff_ffff);
    send(brt_pkg::REQ_DELETE, 32'hab00_0000, 32'hff00_0000);
    send(brt_pkg::REQ_DELETE, 32'h0, 32'hffff_ffff);
    send(brt_pkg::REQ_INSERT, 32'h8000_0001, 32'h8000_0001, 32'h55);
    send(brt_pkg::REQ_FIND, 32'h8000_0000, 32'h8000_0000, 0, 1);
    drain();

    // Random phases across idling modes and both byte orders
    write_swap(1);
    random_phase(300);
    drain();
    write_swap(0);
    idle_pct = 81;
    random_phase(300);
    drain();
    write_swap(1);
    idle_pct = 0;
    stall_pct = 81;
    random_phase(300);
    drain();
    write_swap(0);
    idle_pct = 34;
    stall_pct = 34;
    random_phase(300);

    // Long receiver hold-off while requests keep coming
    hold_start = 1;
    idle_pct = 0;
    stall_pct = 0;
    random_phase(40);
    drain();

    // Fill the node pool with full-length keys, then remove them all
    for (int i = 0; i < 220; i++) begin
      k = $urandom;
      full_keys.push_back(k);
      send(brt_pkg::REQ_INSERT, k, 32'hffff_ffff, $urandom);
    end
    random_phase(30);
    foreach (full_keys[i]) send(brt_pkg::REQ_DELETE, full_keys[i], 32'hffff_ffff);
    random_phase(100);
    drain();

    if (sb.errors == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end
endmodule

FILE: files.f
src/brt_pkg.sv
src/brt_req_if.sv
src/brt_rsp_if.sv
src/brt_node_mem.sv
src/binary_radix_trie_prefix_table_unit.sv
sim/tb.sv
